// ----- design/scr_pkg.sv -----
package scr_pkg;

    localparam int MAX_FRAMES    = 16;
    localparam int PAGE_BITS     = 16;
    localparam int FRAME_W       = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int COUNT_W       = $clog2(MAX_FRAMES + 1);
    localparam int IN_W          = 16;
    localparam int FRAME_IDX_W   = 4;
    localparam int EV_PAGE_W     = 16;
    localparam int TOTAL_W       = 32;
    localparam int CFG_W         = 5;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_W-1:0]      FRAMES_RESET = CFG_W'(4);
    localparam logic [APB_ADDR_W-1:0] ADDR_FRAMES  = APB_ADDR_W'(0);

    typedef struct packed {
        logic                 valid;
        logic [PAGE_BITS-1:0] page;
    } t_req;

    // Packed from the top down, so the hit flag lands in bit 0.
    typedef struct packed {
        logic [TOTAL_W-1:0]     fault_count;
        logic [TOTAL_W-1:0]     hit_count;
        logic [EV_PAGE_W-1:0]   evicted_page;
        logic                   evicted_valid;
        logic [FRAME_IDX_W-1:0] frame_index;
        logic                   hit;
    } t_result;

    localparam int OUT_W = (($bits(t_result) + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_LOOK  = 2'b01,
        ST_SWEEP = 2'b10
    } t_back_state;

    function automatic logic [FRAME_W-1:0] next_frame(input logic [FRAME_W-1:0] h,
                                                      input logic [COUNT_W-1:0] n);
        logic [COUNT_W:0] h1;
        h1 = {1'b0, COUNT_W'(h)} + 1'b1;
        return (h1 < {1'b0, n}) ? h1[FRAME_W-1:0] : '0;
    endfunction

endpackage

// ----- design/scr_front.sv -----
module scr_front
    import scr_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [IN_W-1:0] i_s_tdata,   // [15:0] requested_page
    input  logic            i_pop,
    output t_req            o_req
);

    logic [PAGE_BITS-1:0] r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    r_wr, r_rd;
    logic [QCNT_W-1:0]    r_cnt;
    logic                 push, pop;

    assign o_s_tready = (r_cnt < QCNT_W'(QUEUE_DEPTH));
    assign push       = i_s_tvalid && o_s_tready;
    assign pop        = i_pop && (r_cnt != '0);

    assign o_req.valid = (r_cnt != '0);
    assign o_req.page  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_s_tdata[PAGE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

endmodule

// ----- design/scr_back.sv -----
module scr_back
    import scr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_frames_in_use,
    input  t_req             i_req,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output t_result          o_res
);

    logic [PAGE_BITS-1:0]  r_pages [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] r_ref;
    logic [COUNT_W-1:0]    r_filled;
    logic [FRAME_W-1:0]    r_hand;
    logic [FRAME_W-1:0]    r_h;
    logic [PAGE_BITS-1:0]  r_page;
    logic [TOTAL_W-1:0]    r_hits, r_faults;
    t_back_state           r_state;
    logic                  r_valid;
    t_result               r_res;

    logic [COUNT_W-1:0]    n_eff, live;
    logic                  found;
    logic [FRAME_W-1:0]    slot, start;
    logic                  out_free, look_go, do_hit, do_fill, do_sweep, do_clear, do_repl;
    logic [TOTAL_W-1:0]    hits_inc, faults_inc;

    always_comb begin
        if (i_frames_in_use == '0) begin
            n_eff = COUNT_W'(1);
        end else if (int'(i_frames_in_use) > MAX_FRAMES) begin
            n_eff = COUNT_W'(MAX_FRAMES);
        end else begin
            n_eff = COUNT_W'(i_frames_in_use);
        end
    end

    assign live = (r_filled < n_eff) ? r_filled : n_eff;

    // Lowest matching frame wins when a page sits in more than one frame.
    always_comb begin
        found = 1'b0;
        slot  = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (!found && (COUNT_W'(i) < live) && (r_pages[i] == i_req.page)) begin
                found = 1'b1;
                slot  = FRAME_W'(i);
            end
        end
    end

    assign start      = (COUNT_W'(r_hand) < n_eff) ? r_hand : '0;
    assign out_free   = !r_valid || i_ready;
    assign look_go    = (r_state == ST_LOOK) && i_req.valid && out_free;
    assign do_hit     = look_go && found;
    assign do_fill    = look_go && !found && (r_filled < n_eff);
    assign do_sweep   = look_go && !found && !(r_filled < n_eff);
    assign do_clear   = (r_state == ST_SWEEP) && r_ref[r_h];
    assign do_repl    = (r_state == ST_SWEEP) && !r_ref[r_h] && out_free;
    assign o_pop      = look_go;
    assign hits_inc   = (r_hits == '1) ? r_hits : r_hits + 1'b1;
    assign faults_inc = (r_faults == '1) ? r_faults : r_faults + 1'b1;

    always_ff @(posedge i_clk) begin
        if (do_fill) begin
            r_pages[r_filled[FRAME_W-1:0]] <= i_req.page;
        end else if (do_repl) begin
            r_pages[r_h] <= r_page;
        end
        if (do_sweep) begin
            r_page <= i_req.page;
        end
        if (do_hit) begin
            r_res.hit           <= 1'b1;
            r_res.frame_index   <= FRAME_IDX_W'(slot);
            r_res.evicted_valid <= 1'b0;
            r_res.evicted_page  <= '0;
            r_res.hit_count     <= hits_inc;
            r_res.fault_count   <= r_faults;
        end else if (do_fill) begin
            r_res.hit           <= 1'b0;
            r_res.frame_index   <= FRAME_IDX_W'(r_filled);
            r_res.evicted_valid <= 1'b0;
            r_res.evicted_page  <= '0;
            r_res.hit_count     <= r_hits;
            r_res.fault_count   <= faults_inc;
        end else if (do_repl) begin
            r_res.hit           <= 1'b0;
            r_res.frame_index   <= FRAME_IDX_W'(r_h);
            r_res.evicted_valid <= 1'b1;
            r_res.evicted_page  <= EV_PAGE_W'(r_pages[r_h]);
            r_res.hit_count     <= r_hits;
            r_res.fault_count   <= faults_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOOK;
            r_ref    <= '0;
            r_filled <= '0;
            r_hand   <= '0;
            r_h      <= '0;
            r_hits   <= '0;
            r_faults <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (do_hit || do_fill || do_repl) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                ST_LOOK: begin
                    if (do_hit) begin
                        r_ref[slot] <= 1'b1;
                        r_hits      <= hits_inc;
                    end else if (do_fill) begin
                        r_ref[r_filled[FRAME_W-1:0]] <= 1'b0;
                        r_filled <= r_filled + 1'b1;
                        r_faults <= faults_inc;
                    end else if (do_sweep) begin
                        r_h     <= start;
                        r_state <= ST_SWEEP;
                    end
                end
                ST_SWEEP: begin
                    // A set bit buys the frame one more pass of the hand.
                    if (do_clear) begin
                        r_ref[r_h] <= 1'b0;
                        r_h        <= next_frame(r_h, n_eff);
                    end else if (do_repl) begin
                        r_hand   <= next_frame(r_h, n_eff);
                        r_faults <= faults_inc;
                        r_state  <= ST_LOOK;
                    end
                end
                default: begin
                    r_state <= ST_LOOK;
                end
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- design/second_chance_page_replacer.sv -----
// Path: a hit or a fill into an empty frame goes through the input queue and then the result
// register; a replacement also passes through the sweep state, which clears set reference bits.
// Throughput: one word per cycle on hits and fills while the output is not stalled; on a
// replacement no new word is taken until the one-frame-per-cycle clock sweep finds its victim.
// Reset (i_rst_n low, synchronous) empties the queue and the output, clears all reference
// bits, the fill count, the hand and both counters, and sets frames_in_use to 4.
module second_chance_page_replacer
    import scr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_W-1:0]       i_s_tdata,  // [15:0] requested_page
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [0] hit, [4:1] frame_index, [5] evicted_valid, [21:6] evicted_page,
    // [53:22] hit_count, [85:54] fault_count, [87:86] zero
    output logic [OUT_W-1:0]      o_m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CFG_W-1:0] r_frames_in_use;
    t_req             req;
    logic             pop;
    t_result          res;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_FRAMES) ? APB_DATA_W'(r_frames_in_use) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= FRAMES_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_FRAMES)) begin
            r_frames_in_use <= pwdata[CFG_W-1:0];
        end
    end

    scr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_pop      (pop),
        .o_req      (req)
    );

    scr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frames_in_use (r_frames_in_use),
        .i_req           (req),
        .o_pop           (pop),
        .o_valid         (o_m_tvalid),
        .i_ready         (i_m_tready),
        .o_res           (res)
    );

    assign o_m_tdata = OUT_W'(res);

endmodule

// ----- design/scr_checker.sv -----
module scr_checker
    import scr_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [OUT_W-1:0] o_m_tdata
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output word valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled output word changed");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[0] |-> !o_m_tdata[5] && (o_m_tdata[21:6] == 16'd0)
                                       && (o_m_tdata[53:22] != 32'd0))
        else $error("hit word reports an eviction or a zero hit count");

    a_fault_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> (o_m_tdata[85:54] != 32'd0)
                                        && (o_m_tdata[5] || (o_m_tdata[21:6] == 16'd0)))
        else $error("fault word has a zero fault count or a stray evicted page");

endmodule

bind second_chance_page_replacer scr_checker u_scr_checker (.*);

// ----- bench/testbench.sv -----
module testbench;
    import scr_pkg::*;

    localparam int RANDOM_REFS   = 1300;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PLAN_LEN      = 25;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_W-1:0]       s_tdata  = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    second_chance_page_replacer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // One row is either a register write or a page reference; typed rows carry
    // the hit, frame and eviction that the sequence makes obvious by hand.
    typedef struct packed {
        logic                 is_cfg;
        logic [15:0]          value;
        logic                 typed;
        logic                 hit;
        logic [3:0]           frame;
        logic                 ev_valid;
        logic [EV_PAGE_W-1:0] ev_page;
    } t_ref_row;

    t_ref_row plan [0:PLAN_LEN-1] = '{
        '{1'b0, 16'h0000, 1'b1, 1'b0, 4'd0, 1'b0, 16'h0000},
        '{1'b0, 16'hFFFF, 1'b1, 1'b0, 4'd1, 1'b0, 16'h0000},
        '{1'b0, 16'h0000, 1'b1, 1'b1, 4'd0, 1'b0, 16'h0000},
        '{1'b0, 16'h5555, 1'b1, 1'b0, 4'd2, 1'b0, 16'h0000},
        '{1'b0, 16'hAAAA, 1'b1, 1'b0, 4'd3, 1'b0, 16'h0000},
        '{1'b0, 16'h1234, 1'b1, 1'b0, 4'd1, 1'b1, 16'hFFFF},
        '{1'b0, 16'hFFFF, 1'b1, 1'b0, 4'd2, 1'b1, 16'h5555},
        '{1'b0, 16'h1234, 1'b1, 1'b1, 4'd1, 1'b0, 16'h0000},
        '{1'b0, 16'hAAAA, 1'b1, 1'b1, 4'd3, 1'b0, 16'h0000},
        '{1'b0, 16'h0000, 1'b1, 1'b1, 4'd0, 1'b0, 16'h0000},
        '{1'b0, 16'h5555, 1'b1, 1'b0, 4'd2, 1'b1, 16'hFFFF},
        '{1'b0, 16'h0000, 1'b1, 1'b1, 4'd0, 1'b0, 16'h0000},
        '{1'b0, 16'h1234, 1'b1, 1'b1, 4'd1, 1'b0, 16'h0000},
        '{1'b0, 16'h5555, 1'b1, 1'b1, 4'd2, 1'b0, 16'h0000},
        '{1'b0, 16'hAAAA, 1'b1, 1'b1, 4'd3, 1'b0, 16'h0000},
        // Every bit is set here, so the sweep goes all the way round.
        '{1'b0, 16'h8000, 1'b1, 1'b0, 4'd3, 1'b1, 16'hAAAA},
        '{1'b1, 16'd0,    1'b0, 1'b0, 4'd0, 1'b0, 16'h0000},
        '{1'b0, 16'h7777, 1'b1, 1'b0, 4'd0, 1'b1, 16'h0000},
        '{1'b1, 16'd31,   1'b0, 1'b0, 4'd0, 1'b0, 16'h0000},
        '{1'b0, 16'h0001, 1'b1, 1'b0, 4'd4, 1'b0, 16'h0000},
        '{1'b0, 16'h7777, 1'b1, 1'b1, 4'd0, 1'b0, 16'h0000},
        '{1'b1, 16'd2,    1'b0, 1'b0, 4'd0, 1'b0, 16'h0000},
        // Page 8000 sits in frame 3 too, but that frame is out of the active set.
        '{1'b0, 16'h8000, 1'b1, 1'b0, 4'd1, 1'b1, 16'h1234},
        '{1'b1, 16'd16,   1'b0, 1'b0, 4'd0, 1'b0, 16'h0000},
        '{1'b0, 16'h8000, 1'b1, 1'b1, 4'd1, 1'b0, 16'h0000}
    };

    // Predictor state.
    logic [PAGE_BITS-1:0] frame_page_q [MAX_FRAMES];
    logic                 ref_bit_q [MAX_FRAMES];
    int unsigned          filled_q;
    int unsigned          hand_q;
    logic [TOTAL_W-1:0]   hits_q;
    logic [TOTAL_W-1:0]   faults_q;
    logic [CFG_W-1:0]     frames_cfg = FRAMES_RESET;

    t_result     pending_lookups [$];
    int unsigned mismatches    = 0;
    int unsigned refs_sent     = 0;
    int unsigned results_seen  = 0;
    int unsigned hits_seen     = 0;
    int unsigned evicts_seen   = 0;
    int unsigned settings_used = 0;
    int unsigned cycle_count   = 0;
    bit          tx_steady     = 1'b0;
    bit          rx_steady     = 1'b0;

    initial begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            frame_page_q[i] = '0;
            ref_bit_q[i]    = 1'b0;
        end
        filled_q = 0;
        hand_q   = 0;
        hits_q   = '0;
        faults_q = '0;
    end

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch in %s: got %0h, expected %0h", field, got, want);
        mismatches++;
    endtask

    function automatic int unsigned active_frames(input logic [CFG_W-1:0] cfg);
        if (cfg == 0)
            return 1;
        if (cfg > MAX_FRAMES)
            return MAX_FRAMES;
        return 32'(cfg);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic replace_page(input logic [PAGE_BITS-1:0] page, output t_result res);
        int unsigned n;
        int unsigned live;
        int unsigned slot;
        int unsigned h;
        int unsigned steps;
        int unsigned i;
        bit          found;
        n     = active_frames(frames_cfg);
        live  = (filled_q < n) ? filled_q : n;
        found = 1'b0;
        slot  = 0;
        res   = '0;
        for (i = 0; i < live; i++) begin
            if (!found && frame_page_q[i] == page) begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found) begin
            ref_bit_q[slot] = 1'b1;
            if (hits_q != '1)
                hits_q++;
        end else begin
            if (filled_q < n) begin
                slot = filled_q;
                filled_q++;
            end else begin
                h     = (hand_q < n) ? hand_q : 0;
                steps = 0;
                while (ref_bit_q[h] && steps < n) begin
                    ref_bit_q[h] = 1'b0;
                    h = (h + 1 < n) ? h + 1 : 0;
                    steps++;
                end
                slot              = h;
                res.evicted_valid = 1'b1;
                res.evicted_page  = frame_page_q[h];
                hand_q            = (h + 1 < n) ? h + 1 : 0;
            end
            frame_page_q[slot] = page;
            ref_bit_q[slot]    = 1'b0;
            if (faults_q != '1)
                faults_q++;
        end
        res.hit         = found;
        res.frame_index = slot[FRAME_IDX_W-1:0];
        res.hit_count   = hits_q;
        res.fault_count = faults_q;
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            s_tvalid = 1'b0;
            s_tdata  = 16'($urandom);
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Presents one page word, waits for it to be taken, then queues what the
    // block should answer. tvalid is left high for a following word.
    task automatic send_ref(input logic [PAGE_BITS-1:0] page, input t_ref_row row);
        t_result want;
        @(negedge i_clk);
        s_tvalid = 1'b1;
        s_tdata  = page;
        do @(posedge i_clk); while (!s_tready);
        replace_page(page, want);
        if (row.typed) begin
            want.hit           = row.hit;
            want.frame_index   = row.frame;
            want.evicted_valid = row.ev_valid;
            want.evicted_page  = row.ev_page;
        end
        pending_lookups.push_back(want);
        refs_sent++;
    endtask

    task automatic settle_block();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_cycle(input logic write, input logic [APB_DATA_W-1:0] data,
                             output logic [APB_DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = ADDR_FRAMES;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_frames(input logic [CFG_W-1:0] value);
        logic [APB_DATA_W-1:0] rdata;
        settle_block();
        apb_cycle(1'b1, APB_DATA_W'(value), rdata);
        frames_cfg = value;
        settings_used++;
        apb_cycle(1'b0, '0, rdata);
        if (rdata !== APB_DATA_W'(value))
            report("frames_in_use readback", rdata, APB_DATA_W'(value));
    endtask

    // Receiver side: random back-pressure, held off during steady phases.
    always @(negedge i_clk) begin : drive_ready
        int hold;
        if (hold > 0) begin
            hold--;
            m_tready = 1'b0;
        end else if (rx_steady) begin
            m_tready = 1'b1;
        end else begin
            hold = pick_gap();
            m_tready = (hold == 0);
            if (hold > 0)
                hold--;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = t_result'(m_tdata[$bits(t_result)-1:0]);
            if (pending_lookups.size() == 0) begin
                report("unexpected result word", m_tdata[31:0], 32'd0);
            end else begin
                want = pending_lookups.pop_front();
                results_seen++;
                hits_seen   += 32'(want.hit);
                evicts_seen += 32'(want.evicted_valid);
                if (got.hit !== want.hit)
                    report("hit", 32'(got.hit), 32'(want.hit));
                if (got.frame_index !== want.frame_index)
                    report("frame_index", 32'(got.frame_index), 32'(want.frame_index));
                if (got.evicted_valid !== want.evicted_valid)
                    report("evicted_valid", 32'(got.evicted_valid), 32'(want.evicted_valid));
                if (got.evicted_page !== want.evicted_page)
                    report("evicted_page", 32'(got.evicted_page), 32'(want.evicted_page));
                if (got.hit_count !== want.hit_count)
                    report("hit_count", got.hit_count, want.hit_count);
                if (got.fault_count !== want.fault_count)
                    report("fault_count", got.fault_count, want.fault_count);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles with %0d results outstanding",
                     cycle_count, pending_lookups.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        logic [PAGE_BITS-1:0] pool [24];
        logic [PAGE_BITS-1:0] page;
        logic [CFG_W-1:0]     cfg;
        int unsigned          random_sent;
        int unsigned          pool_n;
        int unsigned          phase_len;
        int unsigned          k;
        int                   r;
        random_sent = 0;
        for (k = 0; k < 24; k++)
            pool[k] = 16'($urandom);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (k = 0; k < PLAN_LEN; k++) begin
            if (plan[k].is_cfg) begin
                set_frames(plan[k].value[CFG_W-1:0]);
            end else begin
                idle_sender(pick_gap());
                send_ref(plan[k].value, plan[k]);
            end
        end

        while (random_sent < RANDOM_REFS) begin
            r = $urandom_range(0, 9);
            case (r)
                0: cfg = CFG_W'(1);
                1: cfg = CFG_W'(MAX_FRAMES);
                2: cfg = '0;
                3: cfg = CFG_W'($urandom_range(MAX_FRAMES + 1, 31));
                default: cfg = CFG_W'($urandom_range(2, MAX_FRAMES - 1));
            endcase
            set_frames(cfg);
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            // A working set the size of the active frames or up to four pages larger keeps both
            // hits and sweeps frequent; part of it carries over between settings.
            pool_n = active_frames(cfg) + $urandom_range(0, 4);
            for (k = 0; k < pool_n; k++) begin
                if ($urandom_range(0, 2) != 0)
                    pool[k] = 16'($urandom);
            end
            phase_len = $urandom_range(20, 100);
            for (k = 0; k < phase_len && random_sent < RANDOM_REFS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    page = pool[$urandom_range(0, pool_n - 1)];
                else if (r < 92)
                    page = 16'($urandom);
                else
                    page = r[0] ? '1 : '0;
                if (!tx_steady)
                    idle_sender(pick_gap());
                send_ref(page, '0);
                random_sent++;
                if ($urandom_range(0, 199) == 0)
                    settle_block();
            end
        end

        rx_steady = 1'b0;
        settle_block();
        $display("%0d page references over %0d frame-count settings", refs_sent, settings_used);
        $display("%0d results checked: %0d hits, %0d evictions", results_seen, hits_seen,
                 evicts_seen);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
design/scr_pkg.sv
design/scr_front.sv
design/scr_back.sv
design/second_chance_page_replacer.sv
design/scr_checker.sv
bench/testbench.sv
